>>> sv/cvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_pkg: shared types and constants of the camera view transform
// Field widths, command and register codes, zoom limits and saturation.
// ----------------------------------------------------------------------------
package cvt_pkg;

   localparam int unsigned COORD_W   = 32;
   localparam int unsigned ZOOM_W    = 12;
   localparam int unsigned TRIG_W    = 16;
   localparam int unsigned OFFS_W    = 29;
   localparam int unsigned DT_W      = 17;
   localparam int unsigned T_W       = DT_W + 3;      // 5 * dt, up to 655355
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // shared multiplier operands and product
   localparam int unsigned MUL_A_W = 40;
   localparam int unsigned MUL_B_W = T_W + 1;         // unsigned T_W fits as signed
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

   // width for the final add before saturation
   localparam int unsigned WIDE_W = 48;

   // zoom divider: numerator (point - offset) and signed quotient
   localparam int unsigned DIV_NUM_W = COORD_W + 1;
   localparam int unsigned QUO_W     = 38;

   localparam int FOLLOW_SPEED = 5;

   localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 12'd26;
   localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 12'd2560;
   localparam logic [ZOOM_W-1:0] ZOOM_RESET = 12'd256;
   localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_W2S  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_S2W  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZOOM     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y = 3'd6;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 48'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -48'sd2147483648;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/camera_view_transform_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// camera_view_transform_unit: 2D camera follow and world/screen mapping
// Keeps a camera position; rotates, scales and offsets points in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : command stream. tuser = cmd (0 tick, 1 world to screen,
//           2 screen to world, 3 read position). tdata = x_in, y_in, dt.
//   rsp_* : one result per command, tdata = x_out, y_out (Q16.16, saturated).
//   csr_* : register writes (target, zoom, cos/sin, offset), only while idle.
// Sequencing: one signed 40x21 multiplier is stepped through the products
//   by the sequencer; screen to world spends most of its time in the
//   one-bit-a-cycle zoom divider, run once for x and once for y. The
//   result is registered into rsp_tdata from the ST_FIN step, once the
//   output register is free or being drained.
// req_tready is high only while the sequencer is idle. A finished result sits
//   in the output register; the next command is accepted meanwhile and only
//   its own completion waits for the output register to free up.
// Reset (synchronous): camera at 0, registers at their defaults (zoom 1.0,
//   cos 1.0), no result pending.
// ----------------------------------------------------------------------------
module camera_view_transform_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req: x_in [31:0], y_in [63:32], dt [80:64], zero fill [87:81]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [87:0]                       req_tdata,
   // req_tuser: cmd [1:0]
   input  logic [cvt_pkg::CMD_W-1:0]         req_tuser,
   // rsp: x_out [31:0], y_out [63:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,
   // configuration write port
   input  logic                              csr_wen,
   input  logic [cvt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);
   import cvt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TK0, ST_TK1, ST_TK2,
      ST_DX_START, ST_DX_WAIT, ST_DY_START, ST_DY_WAIT,
      ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_ROT5, ST_ROT6,
      ST_ZM1, ST_FIN
   } state_type;

   localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32'sd32768);
   localparam logic signed [PROD_W-1:0] RND14 = PROD_W'(32'sd8192);
   localparam logic signed [PROD_W-1:0] RND8  = PROD_W'(32'sd128);

   state_type state_ff, state_in;

   // configuration
   logic signed [COORD_W-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic        [ZOOM_W-1:0]  zoom_ff, zoom_in;
   logic signed [TRIG_W-1:0]  cos_ff, cos_in, sin_ff, sin_in;
   logic        [OFFS_W-1:0]  off_x_ff, off_x_in, off_y_ff, off_y_in;

   // camera state
   logic signed [COORD_W-1:0] cam_x_ff, cam_x_in, cam_y_ff, cam_y_in;

   // per-command working registers
   logic                      inv_ff, inv_in;        // screen to world
   logic signed [COORD_W-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic        [T_W-1:0]     t_ff, t_in;
   logic signed [MUL_A_W-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [MUL_A_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [PROD_W-1:0]  prod_ff, acc_ff, acc_in;
   logic signed [COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // shared multiplier
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   // rounded views of the product and accumulator
   logic signed [PROD_W-1:0]  rnd16_w, rnd8_w, rot_w;

   // divider
   logic                        div_start;
   logic signed [DIV_NUM_W-1:0] div_numer;
   logic signed [QUO_W-1:0]     div_quo;
   div_status_type              div_stat;

   logic [ZOOM_W-1:0] zoom_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};

   assign div_start = (state_ff == ST_DX_START) || (state_ff == ST_DY_START);
   assign div_numer = (state_ff == ST_DX_START)
                      ? DIV_NUM_W'(pt_x_ff) - $signed(DIV_NUM_W'(off_x_ff))
                      : DIV_NUM_W'(pt_y_ff) - $signed(DIV_NUM_W'(off_y_ff));

   cvt_zoom_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .zoom     (zoom_ff),
      .quotient (div_quo),
      .status   (div_stat)
   );

   // multiplier operand select per sequencer step
   always_comb begin
      mul_en = 1'b1;
      mul_a  = u_ff;
      mul_b  = MUL_B_W'(cos_ff);
      unique case (state_ff)
         ST_TK0: begin
            mul_a = MUL_A_W'(tgt_x_ff) - MUL_A_W'(cam_x_ff);
            mul_b = $signed(MUL_B_W'(t_ff));
         end
         ST_TK1: begin
            mul_a = MUL_A_W'(tgt_y_ff) - MUL_A_W'(cam_y_ff);
            mul_b = $signed(MUL_B_W'(t_ff));
         end
         ST_ROT0: begin
            mul_a = u_ff;
            mul_b = MUL_B_W'(cos_ff);
         end
         ST_ROT1: begin
            mul_a = v_ff;
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_ROT2: begin
            mul_a = v_ff;
            mul_b = MUL_B_W'(cos_ff);
         end
         ST_ROT3: begin
            mul_a = u_ff;
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_ROT4: begin
            mul_a  = rx_ff;
            mul_b  = $signed(MUL_B_W'(zoom_ff));
            mul_en = !inv_ff;
         end
         ST_ROT6: begin
            mul_a  = ry_ff;
            mul_b  = $signed(MUL_B_W'(zoom_ff));
            mul_en = !inv_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rnd16_w = (prod_ff + RND16) >>> 16;
      rnd8_w  = (prod_ff + RND8) >>> 8;
      rot_w   = (acc_ff + RND14) >>> 14;

      // register writes; zoom saturates on the way in
      zoom_wr = csr_wdata[ZOOM_W-1:0];
      if (zoom_wr < ZOOM_MIN) begin
         zoom_wr = ZOOM_MIN;
      end else if (zoom_wr > ZOOM_MAX) begin
         zoom_wr = ZOOM_MAX;
      end
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      zoom_in  = zoom_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_TARGET_X: tgt_x_in = $signed(csr_wdata);
            REG_TARGET_Y: tgt_y_in = $signed(csr_wdata);
            REG_ZOOM:     zoom_in  = zoom_wr;
            REG_COS:      cos_in   = $signed(csr_wdata[TRIG_W-1:0]);
            REG_SIN:      sin_in   = $signed(csr_wdata[TRIG_W-1:0]);
            REG_OFFSET_X: off_x_in = csr_wdata[OFFS_W-1:0];
            REG_OFFSET_Y: off_y_in = csr_wdata[OFFS_W-1:0];
            default: begin
            end
         endcase
      end

      state_in = state_ff;
      cam_x_in = cam_x_ff;
      cam_y_in = cam_y_ff;
      inv_in   = inv_ff;
      pt_x_in  = pt_x_ff;
      pt_y_in  = pt_y_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      acc_in   = acc_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;

      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pt_x_in = $signed(req_tdata[31:0]);
               pt_y_in = $signed(req_tdata[63:32]);
               t_in    = T_W'(req_tdata[80:64]) * T_W'(FOLLOW_SPEED);
               inv_in  = (req_tuser == CMD_S2W);
               u_in    = MUL_A_W'($signed(req_tdata[31:0])) - MUL_A_W'(cam_x_ff);
               v_in    = MUL_A_W'($signed(req_tdata[63:32])) - MUL_A_W'(cam_y_ff);
               unique case (req_tuser)
                  CMD_TICK: state_in = ST_TK0;
                  CMD_W2S:  state_in = ST_ROT0;
                  CMD_S2W:  state_in = ST_DX_START;
                  CMD_NONE: begin
                     res_x_in = cam_x_ff;
                     res_y_in = cam_y_ff;
                     state_in = ST_FIN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TK0: state_in = ST_TK1;
         ST_TK1: begin
            res_x_in = sat32(WIDE_W'(rnd16_w) + WIDE_W'(cam_x_ff));
            cam_x_in = res_x_in;
            state_in = ST_TK2;
         end
         ST_TK2: begin
            res_y_in = sat32(WIDE_W'(rnd16_w) + WIDE_W'(cam_y_ff));
            cam_y_in = res_y_in;
            state_in = ST_FIN;
         end
         ST_DX_START: state_in = ST_DX_WAIT;
         ST_DX_WAIT: begin
            if (div_stat.done) begin
               u_in     = MUL_A_W'(div_quo);
               state_in = ST_DY_START;
            end
         end
         ST_DY_START: state_in = ST_DY_WAIT;
         ST_DY_WAIT: begin
            if (div_stat.done) begin
               v_in     = MUL_A_W'(div_quo);
               state_in = ST_ROT0;
            end
         end
         ST_ROT0: state_in = ST_ROT1;
         ST_ROT1: begin
            acc_in   = prod_ff;                                   // u*c
            state_in = ST_ROT2;
         end
         ST_ROT2: begin
            acc_in   = inv_ff ? acc_ff - prod_ff : acc_ff + prod_ff;  // +- v*s
            state_in = ST_ROT3;
         end
         ST_ROT3: begin
            rx_in    = MUL_A_W'(rot_w);
            acc_in   = prod_ff;                                   // v*c
            state_in = ST_ROT4;
         end
         ST_ROT4: begin
            acc_in   = inv_ff ? acc_ff + prod_ff : acc_ff - prod_ff;  // -+ u*s
            state_in = ST_ROT5;
         end
         ST_ROT5: begin
            ry_in = MUL_A_W'(rot_w);
            if (inv_ff) begin
               res_x_in = sat32(WIDE_W'(rx_ff) + WIDE_W'(cam_x_ff));
            end else begin
               res_x_in = sat32(WIDE_W'(rnd8_w) + $signed(WIDE_W'(off_x_ff)));
            end
            state_in = ST_ROT6;
         end
         ST_ROT6: begin
            if (inv_ff) begin
               res_y_in = sat32(WIDE_W'(ry_ff) + WIDE_W'(cam_y_ff));
               state_in = ST_FIN;
            end else begin
               state_in = ST_ZM1;
            end
         end
         ST_ZM1: begin
            res_y_in = sat32(WIDE_W'(rnd8_w) + $signed(WIDE_W'(off_y_ff)));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
         zoom_ff      <= ZOOM_RESET;
         cos_ff       <= COS_RESET;
         sin_ff       <= '0;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cam_x_ff     <= cam_x_in;
         cam_y_ff     <= cam_y_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         zoom_ff      <= zoom_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      inv_ff   <= inv_in;
      pt_x_ff  <= pt_x_in;
      pt_y_ff  <= pt_y_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      acc_ff   <= acc_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_zoom_range: assert property (@(posedge clock) disable iff (reset)
      (zoom_ff >= ZOOM_MIN) && (zoom_ff <= ZOOM_MAX))
      else $error("zoom register outside its saturation limits");

   a_cam_moves_on_tick: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ((cam_x_ff != $past(cam_x_ff)) || (cam_y_ff != $past(cam_y_ff))))
      |-> (($past(state_ff) == ST_TK1) || ($past(state_ff) == ST_TK2)))
      else $error("camera position changed outside a tick");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised outside the hand-over step");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_no_accept_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_tready)
      else $error("command transfer possible while divider runs");

endmodule
`default_nettype wire

>>> sv/cvt_zoom_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_zoom_div: radix-2 divider for the screen-to-world zoom
// quotient = round(numer * 256 / zoom), halves away from zero, one bit a cycle.
// ----------------------------------------------------------------------------
module cvt_zoom_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [cvt_pkg::DIV_NUM_W-1:0] numer,
   input  logic        [cvt_pkg::ZOOM_W-1:0]    zoom,
   output logic signed [cvt_pkg::QUO_W-1:0]     quotient,
   output cvt_pkg::div_status_type              status
);
   import cvt_pkg::*;

   localparam int unsigned MAG_W = DIV_NUM_W - 1;
   localparam int unsigned DVD_W = MAG_W + 9;        // mag * 512 + zoom
   localparam int unsigned DVS_W = ZOOM_W + 1;       // 2 * zoom
   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;

   logic [MAG_W-1:0] mag;
   logic [DVS_W:0]   trial;
   logic             ge;

   always_comb begin
      mag   = '0;
      trial = {rem_ff, quo_ff[DVD_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;

      if (start) begin
         neg_in  = numer[DIV_NUM_W-1];
         mag     = numer[DIV_NUM_W-1] ? MAG_W'(-numer) : MAG_W'(numer);
         quo_in  = {mag, 9'b0} + DVD_W'(zoom);
         rem_in  = '0;
         dvs_in  = {zoom, 1'b0};
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // quotient is below 2^36, so the top bit of the slice is zero
   assign quotient = neg_ff ? -$signed(quo_ff[QUO_W-1:0]) : $signed(quo_ff[QUO_W-1:0]);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire
